// ----- src/plasma_pixel_color_unit_assert.svh -----
// Assertion macros for the plasma pixel color unit.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PLASMA_PIXEL_COLOR_UNIT_ASSERT_SVH
`define PLASMA_PIXEL_COLOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset
`define PPC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("plasma pixel color: assertion failed");
// Condition in one cycle implies a property in the next
`define PPC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("plasma pixel color: assertion failed");
`else
`define PPC_ASSERT(label, prop)
`define PPC_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- src/ppc_pkg.sv -----
// Shared types, constants and helper functions for the plasma pixel color unit.
// No dependencies.
package ppc_pkg;

    localparam int unsigned COORD_W   = 21;
    localparam int unsigned K_W       = 26;
    localparam int unsigned SIN_W     = 18;
    localparam int unsigned ROOT_IN_W = 48;
    localparam int unsigned ROOT_W    = 24;
    localparam int unsigned CHAN_W    = 7;
    localparam int unsigned PHASE_W   = 32;

    // Radians-to-turns factors, 32 fraction bits
    localparam logic [31:0] PER_2PI  = 32'd683565276;
    localparam logic [31:0] PER_4PI  = 32'd341782638;
    localparam logic [31:0] PER_10PI = 32'd136713055;
    localparam logic [31:0] PER_6PI  = 32'd227855092;

    localparam logic [31:0] QUARTER_TURN   = 32'd1073741824;
    localparam logic [31:0] THIRD_TURN     = 32'd1431655765;
    localparam logic [31:0] TWO_THIRD_TURN = 32'd2863311531;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 7'd64;

    typedef enum logic [1:0] {
        PAL_RED_GREEN = 2'd0,
        PAL_RED_CYAN  = 2'd1,
        PAL_RAINBOW   = 2'd2,
        PAL_GREY      = 2'd3
    } palette_t;

    // Remainder and partial root of the bitwise square root
    typedef struct packed {
        logic [ROOT_IN_W-1:0] rem;
        logic [ROOT_IN_W-1:0] acc;
    } root_state_t;

    // One digit of the restoring square root
    function automatic root_state_t root_step(root_state_t s, logic [ROOT_IN_W-1:0] one_bit);
        root_state_t          r;
        logic [ROOT_IN_W-1:0] trial;
        trial = s.acc + one_bit;
        if (s.rem >= trial) begin
            r.rem = s.rem - trial;
            r.acc = (s.acc >> 1) + one_bit;
        end else begin
            r.rem = s.rem;
            r.acc = s.acc >> 1;
        end
        return r;
    endfunction

    // Q16 radians times a turn factor, kept as a 32-bit phase
    function automatic logic [PHASE_W-1:0] phase_of(logic signed [K_W-1:0] k,
                                                     logic [31:0] f);
        logic signed [63:0] p;
        p = 64'(k) * $signed({32'd0, f});
        return p[47:16];
    endfunction

    // (1 + sin) * 32, truncated
    function automatic logic [CHAN_W-1:0] channel_of(logic signed [SIN_W-1:0] s);
        logic [18:0] t;
        t = 19'(s) + 19'd65536;
        return t[17:11];
    endfunction

endpackage

// ----- src/plasma_pixel_color_unit.sv -----
// Plasma pixel color unit: top level with coordinate, wave and radial pipeline.
// Depends on ppc_pkg, ppc_sine, ppc_root, ppc_palette and the assertion header.
//
// Takes one pixel beat (col, row, frame_count) per clock while s_ready is high;
// its color shows on the result port after 31 register stages, one beat per
// clock sustained while m_ready is high. The whole datapath is a single pipeline
// with a common advance enable: it moves whenever the output register is empty
// or being taken, and s_ready is that enable. Latency is set by the 12-stage
// square root (two bits per stage) and three sine lookups in series. The user
// must write palette_mode only while no beat is in flight; no logic enforces it.
`include "plasma_pixel_color_unit_assert.svh"

module plasma_pixel_color_unit #(
    parameter int GRID_SIZE        = 12,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_col,
    input  logic [3:0]  s_row,
    input  logic [15:0] s_frame_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_red,
    output logic [6:0]  m_green,
    output logic [6:0]  m_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_palette_mode
);

    localparam int LAT = 31;
    localparam int XD  = 6;
    localparam int TD  = 20;
    localparam int SD  = 19;

    localparam int CW = ppc_pkg::COORD_W;
    localparam int KW = ppc_pkg::K_W;
    localparam int SW = ppc_pkg::SIN_W;

    logic [LAT-1:0]     vld_reg;
    logic               en;
    ppc_pkg::palette_t  palette_mode_reg;

    logic signed [CW-1:0] coord_tab [16];
    logic signed [CW-1:0] xx_reg [XD];
    logic signed [CW-1:0] yy_reg [XD];
    logic [15:0]          fc_reg;

    logic signed [KW-1:0] kx_reg, ky_reg, kxy_reg;
    logic [31:0]          tp_reg [TD];
    logic [31:0]          th_reg, t10_reg, t6_reg;
    logic [31:0]          p1_reg, p2_reg, p3_reg, pcx_reg, pcy_reg, p4_reg;

    logic signed [SW-1:0] s1, s2, s3, s4, s_cx, s_cy;
    logic signed [19:0]   sum3_reg [SD];
    logic signed [21:0]   cx_reg, cy_reg;
    logic [43:0]          cxsq, cysq;
    logic [21:0]          sqx_reg, sqy_reg;
    logic [22:0]          sqsum;
    logic [29:0]          r2_next, r2_reg;
    logic [ppc_pkg::ROOT_W-1:0] root;
    logic signed [19:0]   sum4;
    logic signed [18:0]   vhalf;
    logic [31:0]          pv_next, pv_reg;

    // Pipeline advance and valid tracking
    assign en        = m_ready || !vld_reg[LAT-1];
    assign s_ready   = en;
    assign m_valid   = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_mode_reg <= ppc_pkg::PAL_RED_GREEN;
        end else if (cfg_valid) begin
            palette_mode_reg <= ppc_pkg::palette_t'(cfg_palette_mode);
        end
    end

    // Grid coordinate table: i / GRID_SIZE in Q16 (truncated), minus one half
    for (genvar i = 0; i < 16; i++) begin : g_coord
        localparam int CV = i * 65536 / GRID_SIZE - 32768;
        assign coord_tab[i] = CW'(CV);
    end

    // Front end: coordinates, wave gains, time phases, wave phases
    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg[0] <= coord_tab[s_col];
            yy_reg[0] <= coord_tab[s_row];
            fc_reg    <= s_frame_count;
            for (int i = 1; i < XD; i++) begin
                xx_reg[i] <= xx_reg[i-1];
                yy_reg[i] <= yy_reg[i-1];
            end

            kx_reg    <= KW'(xx_reg[0]) * KW'(10);
            ky_reg    <= KW'(yy_reg[0]) * KW'(10);
            kxy_reg   <= (KW'(xx_reg[0]) + KW'(yy_reg[0])) * KW'(10);
            tp_reg[0] <= {16'd0, fc_reg} * ppc_pkg::PER_2PI;
            th_reg    <= {16'd0, fc_reg} * ppc_pkg::PER_4PI;
            t10_reg   <= {16'd0, fc_reg} * ppc_pkg::PER_10PI;
            t6_reg    <= {16'd0, fc_reg} * ppc_pkg::PER_6PI;
            for (int i = 1; i < TD; i++) begin
                tp_reg[i] <= tp_reg[i-1];
            end

            p1_reg  <= ppc_pkg::phase_of(kx_reg, ppc_pkg::PER_2PI) + tp_reg[0];
            p2_reg  <= ppc_pkg::phase_of(ky_reg, ppc_pkg::PER_4PI) + th_reg;
            p3_reg  <= ppc_pkg::phase_of(kxy_reg, ppc_pkg::PER_4PI) + th_reg;
            pcx_reg <= t10_reg;
            pcy_reg <= t6_reg + ppc_pkg::QUARTER_TURN;
        end
    end

    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_1 (
        .aclk(aclk), .en(en), .phase(p1_reg), .sine(s1));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_2 (
        .aclk(aclk), .en(en), .phase(p2_reg), .sine(s2));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_3 (
        .aclk(aclk), .en(en), .phase(p3_reg), .sine(s3));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_cx (
        .aclk(aclk), .en(en), .phase(pcx_reg), .sine(s_cx));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_cy (
        .aclk(aclk), .en(en), .phase(pcy_reg), .sine(s_cy));

    // Radial term: moving center, squared distance, radicand
    assign cxsq    = 44'(cx_reg) * 44'(cx_reg);
    assign cysq    = 44'(cy_reg) * 44'(cy_reg);
    assign sqsum   = 23'(sqx_reg) + 23'(sqy_reg);
    assign r2_next = 30'(sqsum) * 30'd100 + 30'd65536;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg      <= 22'(s_cx >>> 1) + 22'(xx_reg[XD-1]);
            cy_reg      <= 22'(s_cy >>> 1) + 22'(yy_reg[XD-1]);
            sum3_reg[0] <= 20'(s1) + 20'(s2) + 20'(s3);
            for (int i = 1; i < SD; i++) begin
                sum3_reg[i] <= sum3_reg[i-1];
            end
            sqx_reg <= cxsq[37:16];
            sqy_reg <= cysq[37:16];
            r2_reg  <= r2_next;
        end
    end

    ppc_root u_root (
        .aclk     (aclk),
        .en       (en),
        .radicand ({2'b00, r2_reg, 16'd0}),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_reg <= ppc_pkg::phase_of($signed({2'b00, root}), ppc_pkg::PER_2PI)
                      + tp_reg[TD-1];
        end
    end

    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_4 (
        .aclk(aclk), .en(en), .phase(p4_reg), .sine(s4));

    // Plasma value halved, as a phase of pi * v
    assign sum4    = sum3_reg[SD-1] + 20'(s4);
    assign vhalf   = 19'(sum4 >>> 1);
    assign pv_next = 32'(vhalf) << 15;

    always_ff @(posedge aclk) begin
        if (en) begin
            pv_reg <= pv_next;
        end
    end

    ppc_palette #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_palette (
        .aclk  (aclk),
        .en    (en),
        .mode  (palette_mode_reg),
        .pv    (pv_reg),
        .red   (m_red),
        .green (m_green),
        .blue  (m_blue)
    );

    // Checks
    `PPC_ASSERT(a_chan_range, m_valid |-> (m_red <= 7'd64) && (m_green <= 7'd64) && (m_blue <= 7'd64))
    `PPC_ASSERT(a_red_full, m_valid && (palette_mode_reg == ppc_pkg::PAL_RED_CYAN) |-> m_red == 7'd64)
    `PPC_ASSERT(a_blue_off, m_valid && (palette_mode_reg == ppc_pkg::PAL_RED_GREEN) |-> m_blue == 7'd0)
    `PPC_ASSERT(a_grey_equal, m_valid && (palette_mode_reg == ppc_pkg::PAL_GREY) |-> (m_red == m_green) && (m_green == m_blue))
    `PPC_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_reg))

endmodule

// ----- src/ppc_sine.sv -----
// Pipelined sine lookup: quadrant fold, quarter-wave ROM, sign restore.
// Depends on ppc_pkg.
module ppc_sine #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [ppc_pkg::PHASE_W-1:0]        phase,
    output logic signed [ppc_pkg::SIN_W-1:0]   sine
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW = 30 + AW;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    typedef logic [16:0] wave_t [SINE_TABLE_DEPTH + 1];

    // Quarter-wave table from a seven-term Taylor series in Q30
    function automatic wave_t build_wave();
        wave_t  w;
        longint x, x2, term, sum, e;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
            x2   = x * x / Q30_ONE;
            term = x;
            sum  = x;
            // Terms x^3/3! through x^13/13!, each from the one before
            term = -(term * x2 / Q30_ONE) / 64'sd6;
            sum  = sum + term;
            term = -(term * x2 / Q30_ONE) / 64'sd20;
            sum  = sum + term;
            term = -(term * x2 / Q30_ONE) / 64'sd42;
            sum  = sum + term;
            term = -(term * x2 / Q30_ONE) / 64'sd72;
            sum  = sum + term;
            term = -(term * x2 / Q30_ONE) / 64'sd110;
            sum  = sum + term;
            term = -(term * x2 / Q30_ONE) / 64'sd156;
            sum  = sum + term;
            if (sum < 0) sum = 0;
            e = (sum + 64'sd8192) >>> 14;
            if (e > 64'sd65536) e = 64'sd65536;
            w[i] = e[16:0];
        end
        return w;
    endfunction

    localparam wave_t WAVE = build_wave();

    logic [MW-1:0] prod;
    logic [AW-1:0] idx;
    logic [AW-1:0] addr_next;
    logic [AW-1:0] addr_reg;
    logic          neg_a_reg;
    logic          neg_b_reg;
    logic [16:0]   mag_reg;

    // Table index from the low 30 phase bits, mirrored in odd quadrants
    assign prod      = MW'(phase[29:0]) * MW'(SINE_TABLE_DEPTH);
    assign idx       = prod[MW-1:30];
    assign addr_next = phase[30] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg  <= addr_next;
            neg_a_reg <= phase[31];
            mag_reg   <= WAVE[addr_reg];
            neg_b_reg <= neg_a_reg;
            sine      <= neg_b_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
    end

endmodule

// ----- src/ppc_root.sv -----
// Pipelined integer square root, two result bits per stage, 12 stages.
// Depends on ppc_pkg.
module ppc_root (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [ppc_pkg::ROOT_IN_W-1:0]   radicand,
    output logic [ppc_pkg::ROOT_W-1:0]      root
);

    localparam int NST = ppc_pkg::ROOT_W / 2;

    ppc_pkg::root_state_t st_reg   [NST];
    ppc_pkg::root_state_t stage_in [NST];

    assign stage_in[0] = '{rem: radicand, acc: '0};

    for (genvar s = 0; s < NST; s++) begin : g_stage
        localparam logic [ppc_pkg::ROOT_IN_W-1:0] B0 =
            ppc_pkg::ROOT_IN_W'(1) << (ppc_pkg::ROOT_IN_W - 2 - 4 * s);
        localparam logic [ppc_pkg::ROOT_IN_W-1:0] B1 =
            ppc_pkg::ROOT_IN_W'(1) << (ppc_pkg::ROOT_IN_W - 4 - 4 * s);

        if (s > 0) begin : g_link
            assign stage_in[s] = st_reg[s-1];
        end

        // Two restoring digits
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[s] <= ppc_pkg::root_step(ppc_pkg::root_step(stage_in[s], B0), B1);
            end
        end
    end

    assign root = st_reg[NST-1].acc[ppc_pkg::ROOT_W-1:0];

endmodule

// ----- src/ppc_palette.sv -----
// Palette stage: maps the plasma phase to red, green, blue.
// Depends on ppc_pkg and ppc_sine.
module ppc_palette #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              en,
    input  ppc_pkg::palette_t                 mode,
    input  logic [ppc_pkg::PHASE_W-1:0]       pv,
    output logic [ppc_pkg::CHAN_W-1:0]        red,
    output logic [ppc_pkg::CHAN_W-1:0]        green,
    output logic [ppc_pkg::CHAN_W-1:0]        blue
);

    logic [ppc_pkg::PHASE_W-1:0]      pa_reg, pb_reg, pc_reg;
    logic signed [ppc_pkg::SIN_W-1:0] sa, sb, sc;
    logic [ppc_pkg::CHAN_W-1:0]       ca, cb, cc;

    // Channel phases; grey bands at five times the rate
    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg <= (mode == ppc_pkg::PAL_GREY) ? 32'(pv * 32'd5) : pv;
            pb_reg <= pv + ((mode == ppc_pkg::PAL_RAINBOW) ? ppc_pkg::THIRD_TURN
                                                           : ppc_pkg::QUARTER_TURN);
            pc_reg <= pv + ppc_pkg::TWO_THIRD_TURN;
        end
    end

    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_a (
        .aclk(aclk), .en(en), .phase(pa_reg), .sine(sa));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_b (
        .aclk(aclk), .en(en), .phase(pb_reg), .sine(sb));
    ppc_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine_c (
        .aclk(aclk), .en(en), .phase(pc_reg), .sine(sc));

    assign ca = ppc_pkg::channel_of(sa);
    assign cb = ppc_pkg::channel_of(sb);
    assign cc = ppc_pkg::channel_of(sc);

    // Output register
    always_ff @(posedge aclk) begin
        if (en) begin
            case (mode)
                ppc_pkg::PAL_RED_GREEN: begin
                    red <= ca; green <= cb; blue <= '0;
                end
                ppc_pkg::PAL_RED_CYAN: begin
                    red <= ppc_pkg::CHAN_FULL; green <= cb; blue <= ca;
                end
                ppc_pkg::PAL_RAINBOW: begin
                    red <= ca; green <= cb; blue <= cc;
                end
                default: begin
                    red <= ca; green <= ca; blue <= ca;
                end
            endcase
        end
    end

endmodule

// ----- bench/plasma_pixel_color_unit_test.sv -----
// Testbench for plasma_pixel_color_unit: an in-bench fixed-point plasma predictor
// checks every color beat. Depends on ppc_pkg and the plasma_pixel_color_unit RTL.
`timescale 1ns / 1ps

module plasma_pixel_color_unit_test;

    localparam int GRID      = 12;
    localparam int DEPTH     = 1024;
    localparam int DRAIN_CYC = 40;

    typedef struct {
        logic [6:0] red;
        logic [6:0] green;
        logic [6:0] blue;
    } pixel_color_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [3:0]  s_col = 0;
    logic [3:0]  s_row = 0;
    logic [15:0] s_frame_count = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [6:0]  m_red, m_green, m_blue;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_palette_mode = 0;

    pixel_color_t      color_q[$];
    longint            wave_lut[DEPTH + 1];
    ppc_pkg::palette_t cur_palette = ppc_pkg::PAL_RED_GREEN;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                recv_hold_cycles = 0;
    int                mismatches = 0;

    plasma_pixel_color_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_col(s_col), .s_row(s_row), .s_frame_count(s_frame_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_palette_mode(cfg_palette_mode)
    );

    always #5 aclk = ~aclk;

    // quarter-wave sine table from a Taylor series in Q30
    function automatic void build_wave_lut();
        longint x, x2, term, sum, e;
        for (int i = 0; i <= DEPTH; i++) begin
            x = 64'sd1686629713 * i / DEPTH;
            x2 = x * x / 64'sd1073741824;
            term = x;
            sum = x;
            for (int n = 1; n <= 6; n++) begin
                term = -(term * x2 / 64'sd1073741824) / longint'((2 * n) * (2 * n + 1));
                sum += term;
            end
            if (sum < 0) sum = 0;
            e = (sum + 8192) >>> 14;
            if (e > 65536) e = 65536;
            wave_lut[i] = e;
        end
    endfunction

    function automatic logic [31:0] rad_to_turns(longint a, logic [31:0] f);
        logic [63:0] p;
        p = 64'(a) * {32'd0, f};
        return p[47:16];
    endfunction

    function automatic longint wave_at(logic [31:0] p);
        longint m;
        int     idx;
        idx = int'((64'(p[29:0]) * DEPTH) >> 30);
        m = p[30] ? wave_lut[DEPTH - idx] : wave_lut[idx];
        return p[31] ? -m : m;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, one;
        res = 0;
        one = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + one) begin
                v = v - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic logic [6:0] chan_level(logic [31:0] p);
        longint s;
        s = 65536 + wave_at(p);
        return 7'(s >> 11);
    endfunction

    // expected color of one pixel under the current palette
    function automatic pixel_color_t plasma_color(logic [3:0] c, logic [3:0] r,
                                                  logic [15:0] f);
        longint       xx, yy, kx, ky, tq, cx, cy, r2, v;
        logic [31:0]  tp, th, pv;
        logic [63:0]  root;
        pixel_color_t px;
        tq = longint'(f) * 65536;
        xx = longint'(c) * 65536 / GRID - 32768;
        yy = longint'(r) * 65536 / GRID - 32768;
        kx = 10 * xx;
        ky = 10 * yy;
        tp = rad_to_turns(tq, ppc_pkg::PER_2PI);
        th = rad_to_turns(tq, ppc_pkg::PER_4PI);
        v = wave_at(rad_to_turns(kx, ppc_pkg::PER_2PI) + tp);
        v += wave_at(rad_to_turns(ky, ppc_pkg::PER_4PI) + th);
        v += wave_at(rad_to_turns(kx + ky, ppc_pkg::PER_4PI) + th);
        cx = (wave_at(rad_to_turns(tq, ppc_pkg::PER_10PI)) >>> 1) + xx;
        cy = (wave_at(rad_to_turns(tq, ppc_pkg::PER_6PI) + ppc_pkg::QUARTER_TURN) >>> 1)
             + yy;
        r2 = 100 * (((cx * cx) >>> 16) + ((cy * cy) >>> 16)) + 65536;
        root = int_sqrt(64'(r2) << 16);
        v += wave_at(rad_to_turns(longint'(root), ppc_pkg::PER_2PI) + tp);
        v = v >>> 1;
        pv = 32'(v << 15);
        case (cur_palette)
            ppc_pkg::PAL_RED_GREEN: begin
                px.red = chan_level(pv);
                px.green = chan_level(pv + ppc_pkg::QUARTER_TURN);
                px.blue = 0;
            end
            ppc_pkg::PAL_RED_CYAN: begin
                px.red = ppc_pkg::CHAN_FULL;
                px.green = chan_level(pv + ppc_pkg::QUARTER_TURN);
                px.blue = chan_level(pv);
            end
            ppc_pkg::PAL_RAINBOW: begin
                px.red = chan_level(pv);
                px.green = chan_level(pv + ppc_pkg::THIRD_TURN);
                px.blue = chan_level(pv + ppc_pkg::TWO_THIRD_TURN);
            end
            default: begin
                px.red = chan_level(pv * 32'd5);
                px.green = px.red;
                px.blue = px.red;
            end
        endcase
        return px;
    endfunction

    // send one pixel beat, idling first at random
    task automatic send_pixel(logic [3:0] c, logic [3:0] r, logic [15:0] f);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1;
        s_col <= c;
        s_row <= r;
        s_frame_count <= f;
        do @(posedge aclk); while (!s_ready);
        color_q.push_back(plasma_color(c, r, f));
    endtask

    task automatic send_gap();
        s_valid <= 0;
        @(posedge aclk);
    endtask

    // hold the sender until every expected beat has come back
    task automatic wait_drained();
        while (color_q.size() != 0) @(posedge aclk);
    endtask

    // drain, then write the palette register
    task automatic set_palette(ppc_pkg::palette_t pal);
        send_gap();
        wait_drained();
        repeat (DRAIN_CYC) @(posedge aclk);
        cfg_valid <= 1;
        cfg_palette_mode <= pal;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        cur_palette = pal;
    endtask

    // result checker
    always @(posedge aclk) begin
        pixel_color_t want;
        if (aresetn && m_valid && m_ready) begin
            if (color_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected color beat %0d %0d %0d",
                                               m_red, m_green, m_blue);
            end else begin
                want = color_q.pop_front();
                if (want.red !== m_red || want.green !== m_green || want.blue !== m_blue) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.red, want.green, want.blue, m_red, m_green, m_blue);
                end
            end
        end
    end

    // receiver ready, with optional long hold-off
    always @(posedge aclk) begin
        if (recv_hold_cycles > 0) begin
            m_ready <= 0;
            recv_hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        ppc_pkg::palette_t pal;
        for (int p = 0; p < 4; p++) begin
            pal = ppc_pkg::palette_t'(p);
            set_palette(pal);
            send_pixel(0, 0, 0);
            send_pixel(15, 15, 16'hFFFF);
            send_pixel(11, 11, 1);
            send_pixel(0, 15, 16'h8000);
            send_pixel(15, 0, 16'hFFFE);
            send_pixel(5, 7, 12345);
        end
    endtask

    task automatic test_random(ppc_pkg::palette_t pal, int count);
        set_palette(pal);
        repeat (count)
            send_pixel(4'($urandom_range(15)), 4'($urandom_range(15)),
                       16'($urandom_range(65535)));
    endtask

    // receiver stalls long enough for the pipeline to fill and back up
    task automatic test_backpressure();
        recv_hold_cycles = 300;
        repeat (80)
            send_pixel(4'($urandom_range(15)), 4'($urandom_range(15)),
                       16'($urandom_range(65535)));
    endtask

    // sender waits for a full drain between bursts
    task automatic test_drain_pause();
        for (int b = 0; b < 5; b++) begin
            send_gap();
            wait_drained();
            repeat (20)
                send_pixel(4'($urandom_range(11)), 4'($urandom_range(11)),
                           16'($urandom_range(65535)));
        end
    endtask

    initial begin
        build_wave_lut();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 27;
        recv_idle_pct = 55;
        test_random(ppc_pkg::PAL_RED_CYAN, 225);
        test_random(ppc_pkg::PAL_GREY, 225);
        send_idle_pct = 55;
        recv_idle_pct = 27;
        test_random(ppc_pkg::PAL_RAINBOW, 225);
        test_random(ppc_pkg::PAL_RED_GREEN, 225);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(ppc_pkg::PAL_GREY, 150);
        test_random(ppc_pkg::PAL_RED_CYAN, 150);
        test_random(ppc_pkg::PAL_RAINBOW, 150);
        test_random(ppc_pkg::PAL_RED_GREEN, 150);
        test_backpressure();
        test_drain_pause();
        send_gap();
        wait_drained();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- plasma_pixel_color_unit.f -----
+incdir+src
src/ppc_pkg.sv
src/ppc_sine.sv
src/ppc_root.sv
src/ppc_palette.sv
src/plasma_pixel_color_unit.sv
bench/plasma_pixel_color_unit_test.sv
